[hdl/sbba_pkg.sv]
package sbba_pkg;

    localparam int SIDE_W = 12;
    localparam int POS_W  = 10;
    localparam int SPAN_W = 13;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_CLEAR = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd              command;
        logic [SIDE_W-1:0] block_side;
    } t_req;

    typedef struct packed {
        logic             granted;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
    } t_resp;

endpackage

[hdl/sbba_slot_ram.sv]
module sbba_slot_ram #(
    parameter int DEPTH = 11,
    parameter int WIDTH = 60
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/square_block_buddy_allocator_core.sv]
// Square block buddy allocator for a (1 << LEVELS) texel square atlas. A request either
// clears the atlas or allocates a square block whose side is rounded up to a power of
// two 2^L; the reply carries granted and the top-left corner (masked to 10 bits).
// One request is handled at a time by a small sequencer around a single level counter:
// sizing doubles the span until it covers the side, giving L; the free-list search
// visits levels from L up to the first non-empty level J; the slot memory is read;
// then one split runs per level from J down to L; and finally the reply register is
// loaded. A clear goes straight to loading the reply. Failed requests (atlas full, or
// side above the atlas) leave the state untouched and reply with granted low. No
// clearing pass is needed after reset.
module square_block_buddy_allocator_core #(
    parameter int LEVELS = 10
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_stall,
    input  sbba_pkg::t_req  i_req,
    output logic            o_resp_valid,
    input  logic            i_resp_stall,
    output sbba_pkg::t_resp o_resp
);

    localparam int PW = LEVELS;
    localparam int IW = $clog2(LEVELS + 1);
    localparam int JW = $clog2(LEVELS + 2);
    localparam int EW = 2 * PW;
    localparam int RW = 3 * EW;
    localparam logic [JW-1:0] TOP_J    = JW'(LEVELS + 1);
    localparam logic [JW-1:0] LEVELS_J = JW'(LEVELS);

    typedef logic [1:0] t_count;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SIZE,
        S_SEARCH,
        S_TAKE,
        S_SPLIT,
        S_DONE
    } t_state;

    t_state                    r_state;
    logic [sbba_pkg::SIDE_W-1:0] r_side;
    logic [sbba_pkg::SPAN_W-1:0] r_span;
    logic [JW-1:0]             r_j;
    logic [JW-1:0]             r_lvl;
    logic [PW-1:0]             r_x;
    logic [PW-1:0]             r_y;
    logic                      r_granted;
    t_count                    r_count [LEVELS+1];
    logic                      r_resp_valid;
    sbba_pkg::t_resp           r_resp;

    logic [IW-1:0]             j_idx;
    logic [JW-1:0]             dst;
    logic [IW-1:0]             dst_idx;
    logic [PW-1:0]             half;
    logic [RW-1:0]             rd_row;
    logic [RW-1:0]             wr_row;
    logic [EW-1:0]             slot_entry;
    logic [sbba_pkg::POS_W-1:0] x_out;
    logic [sbba_pkg::POS_W-1:0] y_out;

    assign j_idx   = r_j[IW-1:0];
    assign dst     = r_j - JW'(1);
    assign dst_idx = dst[IW-1:0];
    assign half    = PW'(1) << dst_idx;
    // entries {y, x}: right, below, diagonal from low to high
    assign wr_row  = {r_y | half, r_x | half, r_y | half, r_x, r_y, r_x | half};

    always_comb begin
        unique case (r_count[j_idx])
            2'd1:    slot_entry = rd_row[2*EW +: EW];
            2'd2:    slot_entry = rd_row[EW +: EW];
            default: slot_entry = rd_row[0 +: EW];
        endcase
    end

    sbba_slot_ram #(
        .DEPTH (LEVELS + 1),
        .WIDTH (RW)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == S_SPLIT),
        .i_wr_addr (dst_idx),
        .i_wr_data (wr_row),
        .i_rd_addr (j_idx),
        .o_rd_data (rd_row)
    );

    generate
        if (PW >= sbba_pkg::POS_W) begin : g_pos_trunc
            assign x_out = r_x[sbba_pkg::POS_W-1:0];
            assign y_out = r_y[sbba_pkg::POS_W-1:0];
        end else begin : g_pos_ext
            assign x_out = {{(sbba_pkg::POS_W-PW){1'b0}}, r_x};
            assign y_out = {{(sbba_pkg::POS_W-PW){1'b0}}, r_y};
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_resp_valid <= 1'b0;
            for (int i = 0; i <= LEVELS; i++) begin
                r_count[i] <= (i == LEVELS) ? 2'd1 : 2'd0;
            end
        end else begin
            if (r_resp_valid && !i_resp_stall && r_state != S_DONE) begin
                r_resp_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        if (i_req.command == sbba_pkg::CMD_CLEAR) begin
                            for (int i = 0; i <= LEVELS; i++) begin
                                r_count[i] <= (i == LEVELS) ? 2'd1 : 2'd0;
                            end
                            r_granted <= 1'b1;
                            r_x       <= '0;
                            r_y       <= '0;
                            r_state   <= S_DONE;
                        end else begin
                            r_side  <= i_req.block_side;
                            r_span  <= sbba_pkg::SPAN_W'(1);
                            r_j     <= '0;
                            r_state <= S_SIZE;
                        end
                    end
                end
                S_SIZE: begin
                    if (r_j == TOP_J) begin
                        r_granted <= 1'b0;
                        r_x       <= '0;
                        r_y       <= '0;
                        r_state   <= S_DONE;
                    end else if ({1'b0, r_side} > r_span) begin
                        r_span <= r_span << 1;
                        r_j    <= r_j + JW'(1);
                    end else begin
                        r_lvl   <= r_j;
                        r_state <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    if (r_j == TOP_J) begin
                        r_granted <= 1'b0;
                        r_x       <= '0;
                        r_y       <= '0;
                        r_state   <= S_DONE;
                    end else if (r_count[j_idx] == 2'd0) begin
                        r_j <= r_j + JW'(1);
                    end else begin
                        r_state <= S_TAKE;
                    end
                end
                S_TAKE: begin
                    // top level holds only the whole atlas at the origin
                    if (r_j == LEVELS_J) begin
                        r_x <= '0;
                        r_y <= '0;
                    end else begin
                        r_x <= slot_entry[PW-1:0];
                        r_y <= slot_entry[EW-1:PW];
                    end
                    r_count[j_idx] <= r_count[j_idx] - 2'd1;
                    r_granted      <= 1'b1;
                    r_state        <= (r_j == r_lvl) ? S_DONE : S_SPLIT;
                end
                S_SPLIT: begin
                    r_count[dst_idx] <= 2'd3;
                    r_j              <= dst;
                    if (dst == r_lvl) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_resp_valid || !i_resp_stall) begin
                        r_resp.granted <= r_granted;
                        r_resp.pos_x   <= x_out;
                        r_resp.pos_y   <= y_out;
                        r_resp_valid   <= 1'b1;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_req_stall  = (r_state != S_IDLE);
    assign o_resp_valid = r_resp_valid;
    assign o_resp       = r_resp;

endmodule

[tb/sbba_placement_monitor.sv]
`timescale 1ns / 100ps

module sbba_placement_monitor #(
    parameter int LEVELS = 10
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    input  logic            i_req_stall,
    input  sbba_pkg::t_req  i_req,
    input  logic            i_resp_valid,
    input  logic            i_resp_stall,
    input  sbba_pkg::t_resp i_resp,
    output int              o_fail_count,
    output int              o_pending
);

    logic [15:0]     corner_x [0:LEVELS][0:2];
    logic [15:0]     corner_y [0:LEVELS][0:2];
    logic [1:0]      free_cnt [0:LEVELS];
    sbba_pkg::t_resp placement_q[$];
    int              fails = 0;

    function automatic void empty_atlas();
        for (int l = 0; l <= LEVELS; l++) begin
            free_cnt[l] = 2'd0;
            for (int s = 0; s < 3; s++) begin
                corner_x[l][s] = '0;
                corner_y[l][s] = '0;
            end
        end
        free_cnt[LEVELS] = 2'd1;
    endfunction

    // one request -> expected reply, updating the free lists
    function automatic sbba_pkg::t_resp place_block(input sbba_pkg::t_req r);
        sbba_pkg::t_resp res;
        int              lvl;
        int              src_lvl;
        int unsigned     span;
        int unsigned     slot;
        int unsigned     half;
        logic [15:0]     x;
        logic [15:0]     y;
        res = '0;
        if (r.command == sbba_pkg::CMD_CLEAR) begin
            empty_atlas();
            res.granted = 1'b1;
            return res;
        end
        lvl = 0;
        span = 1;
        while (r.block_side > span && lvl < 16) begin
            span = span << 1;
            lvl++;
        end
        if (lvl > LEVELS) return res;
        src_lvl = lvl;
        while (src_lvl <= LEVELS && free_cnt[src_lvl] == 2'd0) src_lvl++;
        if (src_lvl > LEVELS) return res;
        slot = (3 - free_cnt[src_lvl]) % 3;
        x = corner_x[src_lvl][slot];
        y = corner_y[src_lvl][slot];
        free_cnt[src_lvl] = free_cnt[src_lvl] - 2'd1;
        // split down, keeping the top-left quarter
        for (int k = src_lvl; k > lvl; k--) begin
            half = 1 << (k - 1);
            corner_x[k-1][0] = x + half[15:0];
            corner_y[k-1][0] = y;
            corner_x[k-1][1] = x;
            corner_y[k-1][1] = y + half[15:0];
            corner_x[k-1][2] = x + half[15:0];
            corner_y[k-1][2] = y + half[15:0];
            free_cnt[k-1] = 2'd3;
        end
        res.granted = 1'b1;
        res.pos_x = x[sbba_pkg::POS_W-1:0];
        res.pos_y = y[sbba_pkg::POS_W-1:0];
        return res;
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_v,
                                        input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        sbba_pkg::t_resp exp_r;
        if (!i_rst_n) begin
            empty_atlas();
            placement_q.delete();
        end else begin
            if (i_req_valid && !i_req_stall)
                placement_q.insert(placement_q.size(), place_block(i_req));
            if (i_resp_valid && !i_resp_stall) begin
                if (placement_q.size() == 0) begin
                    $error("reply with no request outstanding: granted %0d x %0d y %0d",
                           i_resp.granted, i_resp.pos_x, i_resp.pos_y);
                    fails++;
                end else begin
                    exp_r = placement_q.pop_front();
                    check_field("granted", exp_r.granted, i_resp.granted);
                    check_field("pos_x", exp_r.pos_x, i_resp.pos_x);
                    check_field("pos_y", exp_r.pos_y, i_resp.pos_y);
                end
            end
        end
        o_pending <= placement_q.size();
        o_fail_count <= fails;
    end

endmodule

[tb/square_block_buddy_allocator_core_test.sv]
`timescale 1ns / 100ps

module square_block_buddy_allocator_core_test;

    localparam int LEVELS    = 10;
    localparam int N_RANDOM  = 625;
    localparam int HOLD_LEN  = 300;

    logic            i_clk;
    logic            i_rst_n = 1'b0;
    logic            req_valid = 1'b0;
    sbba_pkg::t_req  req = '0;
    logic            req_stall;
    logic            resp_valid;
    logic            resp_stall = 1'b0;
    sbba_pkg::t_resp resp;

    int    fail_count;
    int    pending;
    int    tx_idle_pct = 22;
    int    rx_idle_pct = 54;
    int    sent_cnt = 0;
    bit    hold_pending = 1'b0;
    bit    hold_done = 1'b0;

    square_block_buddy_allocator_core #(.LEVELS(LEVELS)) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (req_valid),
        .o_req_stall  (req_stall),
        .i_req        (req),
        .o_resp_valid (resp_valid),
        .i_resp_stall (resp_stall),
        .o_resp       (resp)
    );

    sbba_placement_monitor #(.LEVELS(LEVELS)) mon (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (req_valid),
        .i_req_stall  (req_stall),
        .i_req        (req),
        .i_resp_valid (resp_valid),
        .i_resp_stall (resp_stall),
        .i_resp       (resp),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // reply side: random stall, plus one long hold-off on demand
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_pending && !hold_done) begin
                resp_stall <= 1'b1;
                repeat (HOLD_LEN) @(posedge i_clk);
                hold_done = 1'b1;
            end
            resp_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    task automatic offer(input sbba_pkg::t_cmd cmd,
                         input logic [sbba_pkg::SIDE_W-1:0] side);
        req_valid <= 1'b1;
        req <= '{command: cmd, block_side: side};
        @(posedge i_clk);
        while (req_stall) @(posedge i_clk);
        sent_cnt++;
        if ($urandom_range(99) < tx_idle_pct) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
    endtask

    // mostly small blocks so the atlas fills gradually
    function automatic logic [sbba_pkg::SIDE_W-1:0] pick_side();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 50) return sbba_pkg::SIDE_W'($urandom_range(64, 1));
        if (sel < 70) return sbba_pkg::SIDE_W'(1 << $urandom_range(10, 0));
        if (sel < 93) return sbba_pkg::SIDE_W'($urandom_range(1024, 65));
        if (sel < 95) return '0;
        return sbba_pkg::SIDE_W'($urandom_range(4095, 1025));
    endfunction

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        offer(sbba_pkg::CMD_ALLOC, 12'd0);
        offer(sbba_pkg::CMD_ALLOC, 12'd1);
        offer(sbba_pkg::CMD_ALLOC, 12'd2);
        offer(sbba_pkg::CMD_ALLOC, 12'd3);
        offer(sbba_pkg::CMD_ALLOC, 12'd1024);
        offer(sbba_pkg::CMD_ALLOC, 12'd1025);
        offer(sbba_pkg::CMD_ALLOC, 12'd2048);
        offer(sbba_pkg::CMD_ALLOC, 12'd4095);
        offer(sbba_pkg::CMD_CLEAR, 12'd4095);
        offer(sbba_pkg::CMD_ALLOC, 12'd1024);
        offer(sbba_pkg::CMD_ALLOC, 12'd1);
        offer(sbba_pkg::CMD_CLEAR, 12'd0);
        repeat (5) offer(sbba_pkg::CMD_ALLOC, 12'd512);
        offer(sbba_pkg::CMD_CLEAR, 12'd7);
        offer(sbba_pkg::CMD_ALLOC, 12'd513);
        offer(sbba_pkg::CMD_CLEAR, 12'd1);
        offer(sbba_pkg::CMD_ALLOC, 12'd256);
        offer(sbba_pkg::CMD_ALLOC, 12'd2);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 3) begin
                tx_idle_pct = 54;
                rx_idle_pct = 22;
            end else if (i == (2 * N_RANDOM) / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            // sender waits for every outstanding request to drain
            if (i == N_RANDOM / 2) begin
                req_valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            if (i == (3 * N_RANDOM) / 4) hold_pending = 1'b1;
            if ($urandom_range(29) == 0)
                offer(sbba_pkg::CMD_CLEAR, sbba_pkg::SIDE_W'($urandom));
            else
                offer(sbba_pkg::CMD_ALLOC, pick_side());
        end

        req_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[files.f]
hdl/sbba_pkg.sv
hdl/sbba_slot_ram.sv
hdl/square_block_buddy_allocator_core.sv
tb/sbba_placement_monitor.sv
tb/square_block_buddy_allocator_core_test.sv
